@@ sv/hrrp_pkg.sv @@
// Shared types, constants and helpers of the hex row record parser.
`timescale 1ns / 1ps

package hrrp_pkg;

   localparam int unsigned MAX_LINE_BYTES_DEF = 256;

   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned CHAR_CNT_W   = 10;
   localparam int unsigned BYTE_CNT_W   = 9;
   localparam int unsigned NIBBLE_W     = 4;

   localparam logic [CHAR_W-1:0]     COLON_CHAR     = 8'h3A;
   localparam logic [CHAR_CNT_W-1:0] MIN_RECORD     = 10'd6;
   localparam logic [BYTE_CNT_W-1:0] DATA_START     = 9'd5;
   localparam logic [CHAR_CNT_W-1:0] CHAR_COUNT_MAX = 10'd1023;

   // Header byte positions within the decoded line
   localparam logic [BYTE_CNT_W-1:0] POS_ARRAY   = 9'd0;
   localparam logic [BYTE_CNT_W-1:0] POS_ROW_HI  = 9'd1;
   localparam logic [BYTE_CNT_W-1:0] POS_ROW_LO  = 9'd2;
   localparam logic [BYTE_CNT_W-1:0] POS_SIZE_HI = 9'd3;
   localparam logic [BYTE_CNT_W-1:0] POS_SIZE_LO = 9'd4;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_LENGTH = 2'd1,
      ERR_COLON  = 2'd2,
      ERR_SIZE   = 2'd3
   } error_type;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic [7:0]  array_id;
      logic [15:0] row_number;
      logic [15:0] row_size;
      logic [7:0]  row_checksum;
      logic [7:0]  verify_sum;
      logic [1:0]  error_code;
   } rsp_type;

   // Non-hex characters decode as zero
   function automatic logic [NIBBLE_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
      logic [NIBBLE_W-1:0] v;
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = NIBBLE_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = NIBBLE_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = NIBBLE_W'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

@@ sv/hrrp_ifs.sv @@
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps

interface hrrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface hrrp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [7:0]  data_index;
   logic [7:0]  array_id;
   logic [15:0] row_number;
   logic [15:0] row_size;
   logic [7:0]  row_checksum;
   logic [7:0]  verify_sum;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output data_byte, output data_index,
                   output array_id, output row_number, output row_size,
                   output row_checksum, output verify_sum, output error_code,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input data_index,
                   input array_id, input row_number, input row_size,
                   input row_checksum, input verify_sum, input error_code,
                   output ready);
endinterface

@@ sv/hex_row_record_parser.sv @@
// Top level of the hex row record parser: character decode, line state and result queue.
`timescale 1ns / 1ps
// A result transaction is registered from the character that causes it.
// Throughput: one character per cycle while the skid slot is free.
// Output: a main result register plus one skid register, so a character is still taken
//   while one finished result waits; input stalls only when both are full.
// Reset (synchronous, active high): empties both result registers and clears the line state.

module hex_row_record_parser #(
   parameter int unsigned MAX_LINE_BYTES = hrrp_pkg::MAX_LINE_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   hrrp_req_if.sink      req_chan,
   hrrp_rsp_if.source    rsp_chan
);
   import hrrp_pkg::*;

   localparam logic [BYTE_CNT_W:0] MAX_BYTES = (BYTE_CNT_W + 1)'(MAX_LINE_BYTES);

   // Line state
   logic [CHAR_CNT_W-1:0] char_count_ff,  char_count_in;
   logic [NIBBLE_W-1:0]   high_nibble_ff, high_nibble_in;
   logic [BYTE_CNT_W-1:0] byte_count_ff,  byte_count_in;
   logic                  start_ok_ff,    start_ok_in;
   logic                  overflow_ff,    overflow_in;
   logic [7:0]            held_array_ff,  held_array_in;
   logic [15:0]           held_row_ff,    held_row_in;
   logic [15:0]           held_size_ff,   held_size_in;
   logic [7:0]            last_byte_ff,   last_byte_in;

   // Result queue: main register and skid register
   logic    out_valid_ff,  skid_valid_ff;
   rsp_type out_data_ff,   skid_data_ff;

   logic                  accept;
   logic                  pop;
   logic                  has_result;
   rsp_type               result;
   logic [7:0]            new_byte;
   logic [BYTE_CNT_W-1:0] data_pos;
   logic                  emit;
   error_type             err;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;

   // Take a character whenever the skid slot is free
   assign req_chan.ready = !skid_valid_ff;

   assign new_byte = {high_nibble_ff, hex_value(req_chan.char_code)};
   assign data_pos = byte_count_ff - DATA_START;

   // Next line state and the result caused by this character
   always_comb begin
      char_count_in  = char_count_ff;
      high_nibble_in = high_nibble_ff;
      byte_count_in  = byte_count_ff;
      start_ok_in    = start_ok_ff;
      overflow_in    = overflow_ff;
      held_array_in  = held_array_ff;
      held_row_in    = held_row_ff;
      held_size_in   = held_size_ff;
      last_byte_in   = last_byte_ff;
      emit           = 1'b0;

      if (char_count_ff == CHAR_COUNT_MAX) begin
         // Saturated line: ignore the character, flag the overflow
         overflow_in = 1'b1;
      end else if (char_count_ff == '0) begin
         // First character of a line: start clean and check for the colon
         high_nibble_in = '0;
         byte_count_in  = '0;
         overflow_in    = 1'b0;
         held_array_in  = '0;
         held_row_in    = '0;
         held_size_in   = '0;
         last_byte_in   = '0;
         start_ok_in    = (req_chan.char_code == COLON_CHAR);
         char_count_in  = CHAR_CNT_W'(1);
      end else begin
         if (char_count_ff[0]) begin
            high_nibble_in = hex_value(req_chan.char_code);
         end else if ({1'b0, byte_count_ff} >= MAX_BYTES) begin
            // Buffer full: drop the byte
            overflow_in = 1'b1;
         end else begin
            unique case (byte_count_ff)
               POS_ARRAY:   held_array_in = new_byte;
               POS_ROW_HI:  held_row_in   = {new_byte, held_row_ff[7:0]};
               POS_ROW_LO:  held_row_in   = {held_row_ff[15:8], new_byte};
               POS_SIZE_HI: held_size_in  = {new_byte, held_size_ff[7:0]};
               POS_SIZE_LO: held_size_in  = {held_size_ff[15:8], new_byte};
               default: begin
                  emit = start_ok_ff && ({7'd0, data_pos} < held_size_ff);
               end
            endcase
            last_byte_in  = new_byte;
            byte_count_in = byte_count_ff + BYTE_CNT_W'(1);
         end
         char_count_in = char_count_ff + CHAR_CNT_W'(1);
      end

      // Error priority: short line, missing colon, odd length or overflow, size mismatch
      if (char_count_in <= MIN_RECORD) begin
         err = ERR_LENGTH;
      end else if (!start_ok_in) begin
         err = ERR_COLON;
      end else if (!char_count_in[0] || overflow_in) begin
         err = ERR_LENGTH;
      end else if ((17'(held_size_in) + 17'(MIN_RECORD)) != 17'(byte_count_in)) begin
         err = ERR_SIZE;
      end else begin
         err = ERR_OK;
      end

      result = '0;
      if (req_chan.line_end) begin
         result.kind         = KIND_SUMMARY;
         result.array_id     = held_array_in;
         result.row_number   = held_row_in;
         result.row_size     = held_size_in;
         result.row_checksum = last_byte_in;
         result.verify_sum   = last_byte_in + held_array_in + held_row_in[7:0]
                             + held_row_in[15:8] + held_size_in[7:0] + held_size_in[15:8];
         result.error_code   = err;
      end else begin
         result.kind       = KIND_DATA;
         result.data_byte  = new_byte;
         result.data_index = data_pos[7:0];
      end
      has_result = req_chan.line_end || emit;
   end

   // Line state registers; clear everything after the line end
   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.line_end)) begin
         char_count_ff  <= '0;
         high_nibble_ff <= '0;
         byte_count_ff  <= '0;
         start_ok_ff    <= 1'b0;
         overflow_ff    <= 1'b0;
         held_array_ff  <= '0;
         held_row_ff    <= '0;
         held_size_ff   <= '0;
         last_byte_ff   <= '0;
      end else if (accept) begin
         char_count_ff  <= char_count_in;
         high_nibble_ff <= high_nibble_in;
         byte_count_ff  <= byte_count_in;
         start_ok_ff    <= start_ok_in;
         overflow_ff    <= overflow_in;
         held_array_ff  <= held_array_in;
         held_row_ff    <= held_row_in;
         held_size_ff   <= held_size_in;
         last_byte_ff   <= last_byte_in;
      end
   end

   // Result queue: advance the skid entry when the main one drains,
   // otherwise drop a new result into the first free slot
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept && has_result) begin
         if (!out_valid_ff || pop) begin
            out_data_ff  <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_data_ff.kind;
   assign rsp_chan.data_byte    = out_data_ff.data_byte;
   assign rsp_chan.data_index   = out_data_ff.data_index;
   assign rsp_chan.array_id     = out_data_ff.array_id;
   assign rsp_chan.row_number   = out_data_ff.row_number;
   assign rsp_chan.row_size     = out_data_ff.row_size;
   assign rsp_chan.row_checksum = out_data_ff.row_checksum;
   assign rsp_chan.verify_sum   = out_data_ff.verify_sum;
   assign rsp_chan.error_code   = out_data_ff.error_code;

endmodule
